// ===== rtl/rsenc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon encoder.
package rsenc_pkg;

	localparam int MAX_PARITY   = 32;
	localparam int PARITY_RESET = 16;
	localparam int GF_W         = 8;
	localparam int CFG_W        = 6;
	localparam int CNT_W        = $clog2(MAX_PARITY + 1);

	localparam logic [GF_W:0]   GF_POLY = 9'h11d;
	localparam logic [GF_W-1:0] GF_ONE  = 8'h01;

	typedef logic [GF_W-1:0] gf_t;
	typedef logic [MAX_PARITY:1][GF_W-1:0] gen_coeff_t;
	typedef logic [MAX_PARITY-1:0][GF_W-1:0] rem_vec_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} gen_status_t;

	// Multiply by alpha: one shift with reduction by the field polynomial.
	function automatic gf_t gf_xtime(input gf_t a);
		logic [GF_W:0] t;
		t = {a, 1'b0};
		if (t[GF_W]) begin
			t = t ^ GF_POLY;
		end
		return t[GF_W-1:0];
	endfunction

	// Shift-and-add multiply in GF(256).
	function automatic gf_t gf_mul(input gf_t a, input gf_t b);
		gf_t x;
		gf_t acc;
		x   = a;
		acc = '0;
		for (int k = 0; k < GF_W; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

	// A written count of zero is taken as one, anything above the maximum as the maximum.
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (int'(v) > MAX_PARITY) begin
			return CNT_W'(MAX_PARITY);
		end else begin
			return CNT_W'(v);
		end
	endfunction

endpackage

// ===== rtl/rsenc_gen_builder.sv =====
`timescale 1ns / 1ps
// Generator polynomial builder: one root multiplied in per cycle after reset or a count write.
module rsenc_gen_builder import rsenc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pipe_idle,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output gen_status_t      status,
	output gen_coeff_t       coeffs
);

	typedef enum logic {ST_IDLE, ST_BUILD} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] step_q;
	gf_t              root_q;
	gen_coeff_t       coeff_q;
	gen_coeff_t       coeff_next;

	assign cfg_ready    = (state_q == ST_IDLE) && pipe_idle;
	assign status.busy  = (state_q == ST_BUILD);
	assign status.count = count_q;
	assign coeffs       = coeff_q;

	// Multiply the current polynomial by (x + root); the leading coefficient is always one.
	always_comb begin
		coeff_next[1] = gf_mul(GF_ONE, root_q) ^ coeff_q[1];
		for (int j = 2; j <= MAX_PARITY; j++) begin
			coeff_next[j] = gf_mul(coeff_q[j-1], root_q) ^ coeff_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUILD;
			count_q <= CNT_W'(PARITY_RESET);
			step_q  <= '0;
			root_q  <= GF_ONE;
			coeff_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						state_q <= ST_BUILD;
						count_q <= clamp_count(cfg_data);
						step_q  <= '0;
						root_q  <= GF_ONE;
						coeff_q <= '0;
					end
				end
				ST_BUILD: begin
					coeff_q <= coeff_next;
					root_q  <= gf_xtime(root_q);
					step_q  <= step_q + 1'b1;
					if (step_q == count_q - 1'b1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rs_gf256_systematic_encoder_core.sv =====
`timescale 1ns / 1ps
// Top level of the systematic Reed-Solomon encoder over GF(256).
// Path: a message item is registered in the input stage on acceptance and then divided
// into the remainder; the last item loads the parity buffer, which offers the parity items.
// Throughput: one message item per cycle unless in_stall is raised; parity items leave one
// per cycle while out_stall is low, even while the next codeword's message items enter.
// Reset: asynchronous and active low; afterwards the generator for 16 parity items is built,
// and a count write rebuilds it, while no item is accepted.
module rs_gf256_systematic_encoder_core import rsenc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [GF_W-1:0]  data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [GF_W-1:0]  parity_byte,
	output logic             last_parity,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	gen_status_t      gen_status;
	gen_coeff_t       gen_coeffs;

	// Input register stage.
	logic             valid_s1;
	gf_t              data_s1;
	logic             last_s1;

	// Division remainder, and the parity buffer that drains to the output.
	rem_vec_t         rem_q;
	rem_vec_t         rem_next;
	rem_vec_t         par_q;
	logic [CNT_W-1:0] par_cnt_q;

	logic             in_fire;
	logic             s1_fire;
	logic             out_fire;
	logic             buf_free;
	logic             cfg_fire;
	logic             pipe_idle;
	gf_t              feedback;

	assign out_fire  = out_valid && !out_stall;
	// The buffer can take a new codeword when empty or when its final item leaves now.
	assign buf_free  = (par_cnt_q == '0) || ((par_cnt_q == CNT_W'(1)) && !out_stall);
	// A last item waits in the input stage until the previous parity has drained.
	assign s1_fire   = valid_s1 && (!last_s1 || buf_free);
	// No message item is taken at the edge that writes the count, so it can never be
	// divided by a generator that is still being rebuilt.
	assign in_stall  = gen_status.busy || cfg_fire || (valid_s1 && !s1_fire);
	assign in_fire   = in_valid && !in_stall;
	assign pipe_idle = !valid_s1 && (par_cnt_q == '0);
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign out_valid   = (par_cnt_q != '0);
	assign parity_byte = par_q[0];
	assign last_parity = (par_cnt_q == CNT_W'(1));

	rsenc_gen_builder u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_idle (pipe_idle),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.status    (gen_status),
		.coeffs    (gen_coeffs)
	);

	// One LFSR step with every tap updated in parallel. Taps at or above the parity count
	// see zero coefficients and a zero neighbour, so they stay clear without any masking.
	always_comb begin
		feedback = data_s1 ^ rem_q[0];
		for (int j = 0; j < MAX_PARITY - 1; j++) begin
			rem_next[j] = rem_q[j+1] ^ gf_mul(feedback, gen_coeffs[j+1]);
		end
		rem_next[MAX_PARITY-1] = gf_mul(feedback, gen_coeffs[MAX_PARITY]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The remainder is cleared after each codeword and whenever the count is rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cfg_fire) begin
			rem_q <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_next;
			end
		end
	end

	// The parity buffer is loaded with the final remainder and shifts one item per accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_cnt_q <= '0;
		end else if (s1_fire && last_s1) begin
			par_cnt_q <= gen_status.count;
		end else if (out_fire) begin
			par_cnt_q <= par_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			par_q <= rem_next;
		end else if (out_fire) begin
			for (int j = 0; j < MAX_PARITY - 1; j++) begin
				par_q[j] <= par_q[j+1];
			end
			par_q[MAX_PARITY-1] <= '0;
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		par_cnt_q <= gen_status.count)
		else $error("parity buffer holds more items than the parity count");

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> (par_cnt_q == gen_status.count))
		else $error("parity buffer not loaded with a full codeword");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> (rem_q == '0) && gen_status.busy)
		else $error("count write did not clear the remainder and start a rebuild");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		gen_status.busy |-> !s1_fire && (par_cnt_q == '0))
		else $error("item processed while the generator is being built");

endmodule
